// File: sv/pifmt_pkg.sv
// Shared types, constants and character helpers for the integer formatter.
// Used by pifmt_digit_reg and printf_integer_formatter_core; depends on nothing.
package pifmt_pkg;

  typedef enum logic [1:0] {
    RDX_DEC,
    RDX_OCT,
    RDX_HEX
  } radix_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_STRIP,
    ST_PLAN,
    ST_LPAD,
    ST_PFX0,
    ST_PFX1,
    ST_SIGN,
    ST_ZERO,
    ST_DIGIT,
    ST_TPAD
  } state_t;

  // Operand size codes.
  localparam logic [1:0] Sz8  = 2'd0;
  localparam logic [1:0] Sz16 = 2'd1;
  localparam logic [1:0] Sz32 = 2'd2;
  localparam logic [1:0] Sz64 = 2'd3;

  // Flag bit positions.
  localparam int unsigned FlLeft  = 0;
  localparam int unsigned FlPlus  = 1;
  localparam int unsigned FlSpace = 2;
  localparam int unsigned FlAlt   = 3;
  localparam int unsigned FlZero  = 4;

  localparam logic [5:0] PrecCap = 6'd60;
  localparam logic [5:0] PrecPtr = 6'd16;

  // Digit counts before leading zeros are stripped.
  localparam logic [4:0] LenHex  = 5'd16;
  localparam logic [4:0] LenOct  = 5'd22;
  localparam logic [4:0] LenDec  = 5'd22;
  localparam logic [4:0] LenNull = 5'd9;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;

  typedef struct packed {
    logic       load;
    logic       dabble;
    logic       shift;
    radix_t     radix;
    logic [1:0] size_code;
  } dig_ctl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    begin
      c = (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
      digit_char = up ? c : (c | 8'h20);
    end
  endfunction

  function automatic logic [7:0] null_char(input logic [3:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        4'd0:    c = 8'h28;
        4'd1:    c = 8'h6E;
        4'd2:    c = 8'h75;
        4'd3:    c = 8'h6C;
        4'd4:    c = 8'h6C;
        4'd5:    c = 8'h70;
        4'd6:    c = 8'h74;
        4'd7:    c = 8'h72;
        4'd8:    c = 8'h29;
        default: c = ChSpace;
      endcase
      null_char = c;
    end
  endfunction

endpackage

// File: sv/pifmt_digit_reg.sv
// Digit shift register: bit-serial double dabble for decimal, direct load for
// octal and hex, and a left shift of one digit per step. Depends on pifmt_pkg.
module pifmt_digit_reg (
  input  logic                clk,
  input  pifmt_pkg::dig_ctl_t ctl,
  input  logic [63:0]         mag,
  output logic [3:0]          top_digit
);

  logic [87:0] dg_r, dg_nxt;
  logic [63:0] src_r, src_nxt;
  logic [87:0] adj;

  // Add three to every BCD nibble of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < 22; i++) begin
      adj[i*4 +: 4] = (dg_r[i*4 +: 4] >= 4'd5) ? (dg_r[i*4 +: 4] + 4'd3) : dg_r[i*4 +: 4];
    end
  end

  always_comb begin
    dg_nxt  = dg_r;
    src_nxt = src_r;
    if (ctl.load) begin
      case (ctl.radix)
        pifmt_pkg::RDX_HEX: dg_nxt = {mag, 24'h0};
        pifmt_pkg::RDX_OCT: dg_nxt = {2'b00, mag, 22'h0};
        default:            dg_nxt = '0;
      endcase
      // The operand is left-aligned so that its top bit enters first.
      case (ctl.size_code)
        pifmt_pkg::Sz8:  src_nxt = {mag[7:0], 56'h0};
        pifmt_pkg::Sz16: src_nxt = {mag[15:0], 48'h0};
        pifmt_pkg::Sz32: src_nxt = {mag[31:0], 32'h0};
        default:         src_nxt = mag;
      endcase
    end else if (ctl.dabble) begin
      dg_nxt  = {adj[86:0], src_r[63]};
      src_nxt = {src_r[62:0], 1'b0};
    end else if (ctl.shift) begin
      if (ctl.radix == pifmt_pkg::RDX_OCT) begin
        dg_nxt = {dg_r[84:0], 3'b000};
      end else begin
        dg_nxt = {dg_r[83:0], 4'h0};
      end
    end
  end

  always_ff @(posedge clk) begin
    dg_r  <= dg_nxt;
    src_r <= src_nxt;
  end

  assign top_digit = (ctl.radix == pifmt_pkg::RDX_OCT) ? {1'b0, dg_r[87:85]} : dg_r[87:84];

endmodule

// File: sv/printf_integer_formatter_core.sv
// Formats one integer request as printf %d/%i/%u/%o/%x/%X/%p text, one ASCII
// character per strobe on out_valid, with out_last on the final character. A request
// is taken when start is high and busy is low; busy then stays high at least until
// the last character has gone. The receiver cannot stall, so characters leave at
// most one per cycle. A request is decoded at the edge that takes it. Decimal then
// shifts every operand bit (8, 16, 32 or 64) through the bit-serial BCD converter;
// every radix then strips leading zero digits (up to 21), plans the padding, and
// then runs the output phases, which emit the characters.
// Depends on pifmt_pkg and pifmt_digit_reg.
module printf_integer_formatter_core #(
  parameter int MAX_FIELD = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [63:0]       in_value_bits,
  input  logic [1:0]        in_size_code,
  input  logic              in_is_signed,
  input  logic [1:0]        in_radix,
  input  logic              in_uppercase,
  input  logic              in_pointer_mode,
  input  logic [4:0]        in_flag_bits,
  input  logic [6:0]        in_field_width,
  input  logic signed [6:0] in_min_digits,
  output logic              out_valid,
  output logic [7:0]        out_character,
  output logic              out_last
);

  localparam logic [6:0] MaxFieldC = 7'(MAX_FIELD);

  pifmt_pkg::state_t   state_r, state_nxt;
  pifmt_pkg::dig_ctl_t dctl;
  logic [3:0]          top_digit;

  // Decoded request, combinational from the input ports.
  pifmt_pkg::radix_t rdx_w;
  logic [1:0]        sc_w;
  logic              sgn_w, up_w, given_w, nullp_w, neg_w, topbit_w;
  logic              alt_w, zero_w, plus_w, space_w, left_w;
  logic [5:0]        prec_w;
  logic [63:0]       mask_w, t_w, mag_w;
  logic [6:0]        wd_w, bits_w;
  logic [1:0]        plen_w;

  // Request registers.
  pifmt_pkg::radix_t rdx_r, rdx_nxt;
  logic up_r, up_nxt, neg_r, neg_nxt, left_r, left_nxt, plus_r, plus_nxt;
  logic space_r, space_nxt, zero_r, zero_nxt, given_r, given_nxt, nullp_r, nullp_nxt;
  logic [5:0] prec_r, prec_nxt;
  logic [6:0] wd_r, wd_nxt;
  logic [1:0] plen_r, plen_nxt;

  // Sequencing counters.
  logic [6:0] bc_r, bc_nxt;
  logic [4:0] len_r, len_nxt;
  logic [6:0] lpad_r, lpad_nxt, zcnt_r, zcnt_nxt, tpad_r, tpad_nxt, rem_r, rem_nxt;

  // Padding plan.
  logic       has_sign;
  logic       prec_wins;
  logic [5:0] body, zp;
  logic [8:0] rest;
  logic [6:0] pad;

  assign busy = (state_r != pifmt_pkg::ST_IDLE);

  always_comb begin
    if (in_pointer_mode) begin
      rdx_w = pifmt_pkg::RDX_HEX;
    end else if (in_radix == 2'(pifmt_pkg::RDX_OCT)) begin
      rdx_w = pifmt_pkg::RDX_OCT;
    end else if (in_radix == 2'(pifmt_pkg::RDX_HEX)) begin
      rdx_w = pifmt_pkg::RDX_HEX;
    end else begin
      rdx_w = pifmt_pkg::RDX_DEC;
    end
    sc_w  = in_pointer_mode ? pifmt_pkg::Sz64 : in_size_code;
    sgn_w = !in_pointer_mode && in_is_signed;
    up_w  = !in_pointer_mode && in_uppercase;

    case (sc_w)
      pifmt_pkg::Sz8:  mask_w = 64'h0000_0000_0000_00FF;
      pifmt_pkg::Sz16: mask_w = 64'h0000_0000_0000_FFFF;
      pifmt_pkg::Sz32: mask_w = 64'h0000_0000_FFFF_FFFF;
      default:         mask_w = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    t_w = in_value_bits & mask_w;
    case (sc_w)
      pifmt_pkg::Sz8:  begin topbit_w = t_w[7];  bits_w = 7'd8;  end
      pifmt_pkg::Sz16: begin topbit_w = t_w[15]; bits_w = 7'd16; end
      pifmt_pkg::Sz32: begin topbit_w = t_w[31]; bits_w = 7'd32; end
      default:         begin topbit_w = t_w[63]; bits_w = 7'd64; end
    endcase
    neg_w   = sgn_w && topbit_w;
    mag_w   = neg_w ? ((~t_w + 64'd1) & mask_w) : t_w;
    nullp_w = in_pointer_mode && (t_w == 64'd0);

    if (in_pointer_mode) begin
      prec_w = pifmt_pkg::PrecPtr;
    end else if (in_min_digits[5:0] > pifmt_pkg::PrecCap) begin
      prec_w = pifmt_pkg::PrecCap;
    end else begin
      prec_w = in_min_digits[5:0];
    end
    given_w = (in_pointer_mode || !in_min_digits[6]) && !nullp_w;

    left_w  = in_flag_bits[pifmt_pkg::FlLeft];
    plus_w  = sgn_w && in_flag_bits[pifmt_pkg::FlPlus];
    space_w = sgn_w && in_flag_bits[pifmt_pkg::FlSpace] && !plus_w;
    alt_w   = (in_flag_bits[pifmt_pkg::FlAlt] || in_pointer_mode) && !nullp_w;
    zero_w  = (in_flag_bits[pifmt_pkg::FlZero] || in_pointer_mode) && !left_w
              && !given_w && !nullp_w;

    if (!alt_w) begin
      plen_w = 2'd0;
    end else if (rdx_w == pifmt_pkg::RDX_OCT) begin
      plen_w = 2'd1;
    end else if (rdx_w == pifmt_pkg::RDX_HEX) begin
      plen_w = 2'd2;
    end else begin
      plen_w = 2'd0;
    end

    wd_w = (in_field_width > MaxFieldC) ? MaxFieldC : in_field_width;
  end

  pifmt_digit_reg u_digits (
    .clk       (clk),
    .ctl       (dctl),
    .mag       (mag_w),
    .top_digit (top_digit)
  );

  // Padding plan from the stripped digit count.
  always_comb begin
    has_sign  = neg_r || plus_r || space_r;
    prec_wins = given_r && (prec_r > {1'b0, len_r});
    body      = prec_wins ? prec_r : {1'b0, len_r};
    zp        = prec_wins ? (prec_r - {1'b0, len_r}) : 6'd0;
    rest      = {2'b00, wd_r} - {7'h0, plen_r} - {8'h0, has_sign} - {3'b000, body};
    pad       = rest[8] ? 7'd0 : rest[6:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pifmt_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (rdx_w == pifmt_pkg::RDX_DEC) ? pifmt_pkg::ST_DABBLE
                                                    : pifmt_pkg::ST_STRIP;
        end
      end
      pifmt_pkg::ST_DABBLE: begin
        if (bc_r == 7'd1) begin
          state_nxt = pifmt_pkg::ST_STRIP;
        end
      end
      pifmt_pkg::ST_STRIP: begin
        if (nullp_r || top_digit != 4'h0 || len_r == 5'd1) begin
          state_nxt = pifmt_pkg::ST_PLAN;
        end
      end
      pifmt_pkg::ST_PLAN: state_nxt = pifmt_pkg::ST_LPAD;
      pifmt_pkg::ST_LPAD: begin
        if (lpad_r <= 7'd1) begin
          state_nxt = pifmt_pkg::ST_PFX0;
        end
      end
      pifmt_pkg::ST_PFX0: state_nxt = pifmt_pkg::ST_PFX1;
      pifmt_pkg::ST_PFX1: state_nxt = pifmt_pkg::ST_SIGN;
      pifmt_pkg::ST_SIGN: state_nxt = pifmt_pkg::ST_ZERO;
      pifmt_pkg::ST_ZERO: begin
        if (zcnt_r <= 7'd1) begin
          state_nxt = pifmt_pkg::ST_DIGIT;
        end
      end
      pifmt_pkg::ST_DIGIT: begin
        if (len_r <= 5'd1) begin
          state_nxt = pifmt_pkg::ST_TPAD;
        end
      end
      pifmt_pkg::ST_TPAD: begin
        if (tpad_r <= 7'd1) begin
          state_nxt = pifmt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pifmt_pkg::ST_IDLE;
    endcase
  end

  // Outputs and digit register control.
  always_comb begin
    out_valid      = 1'b0;
    out_character  = pifmt_pkg::ChSpace;
    dctl.load      = 1'b0;
    dctl.dabble    = 1'b0;
    dctl.shift     = 1'b0;
    dctl.radix     = (state_r == pifmt_pkg::ST_IDLE) ? rdx_w : rdx_r;
    dctl.size_code = sc_w;
    case (state_r)
      pifmt_pkg::ST_IDLE:   dctl.load = start;
      pifmt_pkg::ST_DABBLE: dctl.dabble = 1'b1;
      pifmt_pkg::ST_STRIP:  dctl.shift = !nullp_r && top_digit == 4'h0 && len_r > 5'd1;
      pifmt_pkg::ST_LPAD:   out_valid = (lpad_r != 7'd0);
      pifmt_pkg::ST_PFX0: begin
        out_valid     = (plen_r != 2'd0);
        out_character = pifmt_pkg::ChZero;
      end
      pifmt_pkg::ST_PFX1: begin
        out_valid     = (plen_r == 2'd2);
        out_character = up_r ? pifmt_pkg::ChUpX : pifmt_pkg::ChLowX;
      end
      pifmt_pkg::ST_SIGN: begin
        out_valid = neg_r || plus_r || space_r;
        if (neg_r) begin
          out_character = pifmt_pkg::ChMinus;
        end else if (plus_r) begin
          out_character = pifmt_pkg::ChPlus;
        end
      end
      pifmt_pkg::ST_ZERO: begin
        out_valid     = (zcnt_r != 7'd0);
        out_character = pifmt_pkg::ChZero;
      end
      pifmt_pkg::ST_DIGIT: begin
        out_valid = 1'b1;
        if (nullp_r) begin
          out_character = pifmt_pkg::null_char(4'(pifmt_pkg::LenNull - len_r));
        end else begin
          out_character = pifmt_pkg::digit_char(top_digit, up_r);
          dctl.shift    = 1'b1;
        end
      end
      pifmt_pkg::ST_TPAD: out_valid = (tpad_r != 7'd0);
      default: ;
    endcase
    out_last = out_valid && (rem_r == 7'd1);
  end

  // Request registers and counters.
  always_comb begin
    rdx_nxt   = rdx_r;
    up_nxt    = up_r;
    neg_nxt   = neg_r;
    left_nxt  = left_r;
    plus_nxt  = plus_r;
    space_nxt = space_r;
    zero_nxt  = zero_r;
    given_nxt = given_r;
    nullp_nxt = nullp_r;
    prec_nxt  = prec_r;
    wd_nxt    = wd_r;
    plen_nxt  = plen_r;
    bc_nxt    = bc_r;
    len_nxt   = len_r;
    lpad_nxt  = lpad_r;
    zcnt_nxt  = zcnt_r;
    tpad_nxt  = tpad_r;
    rem_nxt   = rem_r;
    case (state_r)
      pifmt_pkg::ST_IDLE: begin
        if (start) begin
          rdx_nxt   = rdx_w;
          up_nxt    = up_w;
          neg_nxt   = neg_w;
          left_nxt  = left_w;
          plus_nxt  = plus_w;
          space_nxt = space_w;
          zero_nxt  = zero_w;
          given_nxt = given_w;
          nullp_nxt = nullp_w;
          prec_nxt  = prec_w;
          wd_nxt    = wd_w;
          plen_nxt  = plen_w;
          bc_nxt    = bits_w;
          if (nullp_w) begin
            len_nxt = pifmt_pkg::LenNull;
          end else if (rdx_w == pifmt_pkg::RDX_HEX) begin
            len_nxt = pifmt_pkg::LenHex;
          end else if (rdx_w == pifmt_pkg::RDX_OCT) begin
            len_nxt = pifmt_pkg::LenOct;
          end else begin
            len_nxt = pifmt_pkg::LenDec;
          end
        end
      end
      pifmt_pkg::ST_DABBLE: bc_nxt = bc_r - 7'd1;
      pifmt_pkg::ST_STRIP: begin
        if (dctl.shift) begin
          len_nxt = len_r - 5'd1;
        end
      end
      pifmt_pkg::ST_PLAN: begin
        lpad_nxt = (!left_r && !zero_r) ? pad : 7'd0;
        zcnt_nxt = (zero_r ? pad : 7'd0) + {1'b0, zp};
        tpad_nxt = left_r ? pad : 7'd0;
        rem_nxt  = pad + {1'b0, body} + {5'h0, plen_r} + {6'h0, has_sign};
      end
      pifmt_pkg::ST_LPAD: begin
        if (lpad_r != 7'd0) begin
          lpad_nxt = lpad_r - 7'd1;
        end
      end
      pifmt_pkg::ST_ZERO: begin
        if (zcnt_r != 7'd0) begin
          zcnt_nxt = zcnt_r - 7'd1;
        end
      end
      pifmt_pkg::ST_DIGIT: len_nxt = len_r - 5'd1;
      pifmt_pkg::ST_TPAD: begin
        if (tpad_r != 7'd0) begin
          tpad_nxt = tpad_r - 7'd1;
        end
      end
      default: ;
    endcase
    if (out_valid) begin
      rem_nxt = rem_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pifmt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdx_r   <= rdx_nxt;
    up_r    <= up_nxt;
    neg_r   <= neg_nxt;
    left_r  <= left_nxt;
    plus_r  <= plus_nxt;
    space_r <= space_nxt;
    zero_r  <= zero_nxt;
    given_r <= given_nxt;
    nullp_r <= nullp_nxt;
    prec_r  <= prec_nxt;
    wd_r    <= wd_nxt;
    plen_r  <= plen_nxt;
    bc_r    <= bc_nxt;
    len_r   <= len_nxt;
    lpad_r  <= lpad_nxt;
    zcnt_r  <= zcnt_nxt;
    tpad_r  <= tpad_nxt;
    rem_r   <= rem_nxt;
  end

endmodule
